/* hw/rtl/mpf_pkg.sv */
`default_nettype none

package mpf_pkg;

  // Field widths
  localparam int unsigned BaseW      = 24;
  localparam int unsigned ExpPortW   = 32;
  localparam int unsigned PowerW     = 24;
  localparam int unsigned ExpWidthDef = 32;

  // Fixed modulus, 2^23 <= M < 2^24
  localparam int unsigned ModW = 24;
  localparam logic [ModW-1:0] Modulus = 24'd10000007;

  // Barrett constant floor(2^(2*ModW) / M), fits in ModW+1 bits
  localparam longint unsigned BarrettMuFull = (64'd1 << (2 * ModW)) / 64'(Modulus);
  localparam logic [ModW:0]   BarrettMu     = (ModW + 1)'(BarrettMuFull);

  // Shared multiplier operands and product
  localparam int unsigned OpW   = ModW + 1;
  localparam int unsigned ProdW = 2 * OpW;

  // Barrett remainder before correction stays below 3*M
  localparam int unsigned RemW = ModW + 2;

  typedef struct packed {
    logic            start;
    logic [ModW-1:0] a;
    logic [ModW-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic            done;
    logic [ModW-1:0] res;
  } mm_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/mpf_if.sv */
`default_nettype none

interface mpf_in_if;
  logic                          valid;
  logic                          ready;
  logic [mpf_pkg::BaseW-1:0]     base;
  logic [mpf_pkg::ExpPortW-1:0]  exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mpf_out_if;
  logic                        valid;
  logic                        ready;
  logic [mpf_pkg::PowerW-1:0]  power;

  modport source (output valid, output power, input ready);
  modport sink   (input valid, input power, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mpf_modmul.sv */
`default_nettype none

// Multi-cycle modular multiply (Barrett), one shared 25x25 multiplier.
// start -> done_q through QUOT, TERM, SUB and FIX; a new start is taken in the done cycle.
module mpf_modmul (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mpf_pkg::mm_req_t req_i,
  output mpf_pkg::mm_rsp_t      rsp_o
);

  localparam int unsigned ModW  = mpf_pkg::ModW;
  localparam int unsigned OpW   = mpf_pkg::OpW;
  localparam int unsigned ProdW = mpf_pkg::ProdW;
  localparam int unsigned RemW  = mpf_pkg::RemW;

  localparam logic [RemW-1:0] Mod1x = RemW'(mpf_pkg::Modulus);
  localparam logic [RemW-1:0] Mod2x = RemW'(2 * 32'(mpf_pkg::Modulus));

  typedef enum logic [2:0] {
    MM_IDLE,
    MM_QUOT,
    MM_TERM,
    MM_SUB,
    MM_FIX
  } state_e;

  state_e            state_q, state_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [RemW-1:0]   plo_q, plo_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [ModW-1:0]   res_q, res_d;
  logic              done_q, done_d;
  logic [OpW-1:0]    op_a, op_b;

  always_comb begin
    state_d = state_q;
    prod_d  = prod_q;
    plo_d   = plo_q;
    rem_d   = rem_q;
    res_d   = res_q;
    done_d  = 1'b0;
    op_a    = {1'b0, req_i.a};
    op_b    = {1'b0, req_i.b};
    unique case (state_q)
      MM_IDLE: begin
        // full product P = a*b
        if (req_i.start) begin
          prod_d  = op_a * op_b;
          state_d = MM_QUOT;
        end
      end
      MM_QUOT: begin
        // q2 = (P >> (n-1)) * mu
        op_a    = {1'b0, prod_q[2*ModW-2:ModW-1]};
        op_b    = mpf_pkg::BarrettMu;
        plo_d   = prod_q[RemW-1:0];
        prod_d  = op_a * op_b;
        state_d = MM_TERM;
      end
      MM_TERM: begin
        // t = (q2 >> (n+1)) * M
        op_a    = {1'b0, prod_q[2*ModW:ModW+1]};
        op_b    = {1'b0, mpf_pkg::Modulus};
        prod_d  = op_a * op_b;
        state_d = MM_SUB;
      end
      MM_SUB: begin
        // r = P - t, below 3M so low bits suffice
        rem_d   = plo_q - prod_q[RemW-1:0];
        state_d = MM_FIX;
      end
      MM_FIX: begin
        priority if (rem_q >= Mod2x) begin
          res_d = ModW'(rem_q - Mod2x);
        end else if (rem_q >= Mod1x) begin
          res_d = ModW'(rem_q - Mod1x);
        end else begin
          res_d = ModW'(rem_q);
        end
        done_d  = 1'b1;
        state_d = MM_IDLE;
      end
      default: begin
        state_d = MM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
      done_q  <= 1'b0;
      prod_q  <= '0;
      plo_q   <= '0;
      rem_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      prod_q  <= prod_d;
      plo_q   <= plo_d;
      rem_q   <= rem_d;
      res_q   <= res_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

`default_nettype wire

/* hw/rtl/modular_power_fixed_modulus.sv */
// Sequence: once a request is accepted, the exponent is scanned MSB first with one square
//   per bit (EXP_WIDTH squares) and one multiply by base per set bit among the used bits.
// Throughput: one request at a time; ready returns in the same cycle as the result is
//   registered; every square and multiply runs on the shared multiplier; a result still
//   held at the output stalls until taken.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
`default_nettype none

module modular_power_fixed_modulus #(
  parameter int unsigned EXP_WIDTH = mpf_pkg::ExpWidthDef  // 1..64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mpf_in_if.sink      in_i,
  mpf_out_if.source   out_o
);

  localparam int unsigned ModW     = mpf_pkg::ModW;
  localparam int unsigned ExpPortW = mpf_pkg::ExpPortW;
  localparam int unsigned CntW     = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

  // Sequencer
  //   ST_IDLE : ready for a request
  //   ST_SQR  : first square of the accumulator (acc = 1)
  //   ST_WSQ  : waiting on a square; on done, multiply by base if the bit is set
  //   ST_WMUL : waiting on the base multiply
  //   ST_DONE : move the accumulator to the output register once it is free
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_WSQ,
    ST_WMUL,
    ST_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic [ModW-1:0]        acc_q, acc_d;
  logic [ModW-1:0]        base_q, base_d;
  logic [EXP_WIDTH-1:0]   exp_q, exp_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [ModW-1:0]        power_q, power_d;
  logic                   out_valid_q, out_valid_d;

  logic [EXP_WIDTH-1:0]   exp_in;
  logic [ModW-1:0]        base_red;
  logic                   last_bit;

  mpf_pkg::mm_req_t       mm_req;
  mpf_pkg::mm_rsp_t       mm_rsp;

  // Only the low EXP_WIDTH exponent bits count; a wider scan sees leading zeros
  if (EXP_WIDTH <= ExpPortW) begin : g_exp_trunc
    assign exp_in = in_i.exponent[EXP_WIDTH-1:0];
  end else begin : g_exp_ext
    assign exp_in = {{(EXP_WIDTH - ExpPortW){1'b0}}, in_i.exponent};
  end

  // Base is below 2^24 < 2M, so one conditional subtract reduces it
  assign base_red = (in_i.base >= mpf_pkg::Modulus) ? (in_i.base - mpf_pkg::Modulus)
                                                    : in_i.base;

  assign last_bit = (cnt_q == '0);

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    base_d      = base_q;
    exp_d       = exp_q;
    cnt_d       = cnt_q;
    power_d     = power_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mm_req      = '{start: 1'b0, a: acc_q, b: acc_q};

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          base_d  = base_red;
          exp_d   = exp_in;
          cnt_d   = CntW'(EXP_WIDTH - 1);
          acc_d   = ModW'(1);
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        mm_req  = '{start: 1'b1, a: acc_q, b: acc_q};
        state_d = ST_WSQ;
      end
      ST_WSQ: begin
        if (mm_rsp.done) begin
          acc_d = mm_rsp.res;
          if (exp_q[EXP_WIDTH-1]) begin
            mm_req  = '{start: 1'b1, a: mm_rsp.res, b: base_q};
            state_d = ST_WMUL;
          end else if (last_bit) begin
            state_d = ST_DONE;
          end else begin
            // next bit: square right away
            exp_d   = exp_q << 1;
            cnt_d   = cnt_q - CntW'(1);
            mm_req  = '{start: 1'b1, a: mm_rsp.res, b: mm_rsp.res};
            state_d = ST_WSQ;
          end
        end
      end
      ST_WMUL: begin
        if (mm_rsp.done) begin
          acc_d = mm_rsp.res;
          if (last_bit) begin
            state_d = ST_DONE;
          end else begin
            exp_d   = exp_q << 1;
            cnt_d   = cnt_q - CntW'(1);
            mm_req  = '{start: 1'b1, a: mm_rsp.res, b: mm_rsp.res};
            state_d = ST_WSQ;
          end
        end
      end
      ST_DONE: begin
        // wait for the output register if the previous result is still held
        if (!out_valid_q || out_o.ready) begin
          power_d     = acc_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      base_q      <= '0;
      exp_q       <= '0;
      cnt_q       <= '0;
      power_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      base_q      <= base_d;
      exp_q       <= exp_d;
      cnt_q       <= cnt_d;
      power_q     <= power_d;
    end
  end

  // Shared modular multiplier
  mpf_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.power = power_q;

endmodule

`default_nettype wire

/* hw/rtl/mpf_checker.sv */
`default_nettype none

module mpf_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [mpf_pkg::PowerW-1:0] out_power_i
);

  // Stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_power_i))
    else $error("result changed while stalled");

  // Every result is fully reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_power_i < mpf_pkg::Modulus)
    else $error("result not below modulus");

  // One request at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while busy");

  // A new result appears only as the block returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result raised while sequencer busy");

endmodule

bind modular_power_fixed_modulus mpf_checker u_mpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_power_i (out_o.power)
);

`default_nettype wire
